### design/sha1md_pkg.sv
`default_nettype none
package sha1md_pkg;

   // Geometry
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned DIGEST_WORDS = 5;

   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);
   localparam logic [2:0] FULL_BYTES = 3'd4;

   // Initial chaining value, entry 0 is H0
   localparam logic [4:0][31:0] INIT_CHAIN = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUNDS,
      ST_FOLD,
      ST_OUT
   } sha1md_state_type;

   typedef enum logic [1:0] {
      PH_NONE,
      PH_ZERO,
      PH_LEN_LO,
      PH_DONE
   } sha1md_phase_type;

   typedef enum logic [2:0] {
      SRC_INPUT,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN_HI,
      SRC_LEN_LO
   } sha1md_src_type;

   // Controller to datapath
   typedef struct packed {
      logic           push;
      sha1md_src_type src;
      logic           round;
      logic           fold;
      logic           clear;
      logic [2:0]     out_idx;
   } sha1md_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic wpos_last;
      logic wpos_14;
      logic round_last;
   } sha1md_status_type;

   // Byte count a word contributes: full unless last, capped at four
   function automatic logic [2:0] clamp_bytes(input logic [2:0] bv, input logic last);
      logic [2:0] nb;
      nb = FULL_BYTES;
      if (last && (bv < FULL_BYTES)) begin
         nb = bv;
      end
      return nb;
   endfunction

   // Keep leading valid bytes and, for fewer than four, place the pad byte after them
   function automatic logic [31:0] pack_word(input logic [31:0] data, input logic [2:0] nb);
      logic [31:0] w;
      unique case (nb)
         3'd0:    w = {PAD_BYTE, 24'h000000};
         3'd1:    w = {data[31:24], PAD_BYTE, 16'h0000};
         3'd2:    w = {data[31:16], PAD_BYTE, 8'h00};
         3'd3:    w = {data[31:8], PAD_BYTE};
         default: w = data;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      priority if (r < 7'd20) begin
         k = K_R0;
      end else if (r < 7'd40) begin
         k = K_R1;
      end else if (r < 7'd60) begin
         k = K_R2;
      end else begin
         k = K_R3;
      end
      return k;
   endfunction

endpackage
`default_nettype wire

### design/sha1md_ctrl.sv
`default_nettype none
module sha1md_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_bytes_valid,
   input  wire logic                       req_last_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [2:0]                      rsp_word_index,
   output logic                            rsp_last_of_digest,
   output sha1md_pkg::sha1md_cmd_type      cmd,
   input  wire sha1md_pkg::sha1md_status_type status
);

   sha1md_pkg::sha1md_state_type state_ff, state_in;
   sha1md_pkg::sha1md_phase_type phase_ff, phase_in;
   logic       pad_word_ff, pad_word_in;
   logic [2:0] out_idx_ff, out_idx_in;

   logic in_take;
   logic out_take;
   logic in_full;

   assign in_take  = (state_ff == sha1md_pkg::ST_IDLE) && req_valid;
   assign out_take = (state_ff == sha1md_pkg::ST_OUT) && !rsp_stall;
   assign in_full  = sha1md_pkg::clamp_bytes(req_bytes_valid, req_last_word)
                     == sha1md_pkg::FULL_BYTES;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (status.wpos_last) begin
                  state_in = sha1md_pkg::ST_ROUNDS;
               end else if (req_last_word) begin
                  state_in = sha1md_pkg::ST_PAD;
               end else begin
                  state_in = sha1md_pkg::ST_IDLE;
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            if (status.wpos_last) begin
               state_in = sha1md_pkg::ST_ROUNDS;
            end
         end
         sha1md_pkg::ST_ROUNDS: begin
            if (status.round_last) begin
               state_in = sha1md_pkg::ST_FOLD;
            end
         end
         sha1md_pkg::ST_FOLD: begin
            unique case (phase_ff)
               sha1md_pkg::PH_NONE: state_in = sha1md_pkg::ST_IDLE;
               sha1md_pkg::PH_DONE: state_in = sha1md_pkg::ST_OUT;
               default:             state_in = sha1md_pkg::ST_PAD;
            endcase
         end
         sha1md_pkg::ST_OUT: begin
            if (out_take && (out_idx_ff == sha1md_pkg::LAST_INDEX)) begin
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1md_pkg::ST_IDLE;
      endcase
   end

   // Padding progress and digest word index
   always_comb begin
      phase_in    = phase_ff;
      pad_word_in = pad_word_ff;
      out_idx_in  = out_idx_ff;
      if (in_take && req_last_word) begin
         phase_in    = sha1md_pkg::PH_ZERO;
         pad_word_in = in_full;
      end
      if (state_ff == sha1md_pkg::ST_PAD) begin
         priority if (pad_word_ff) begin
            pad_word_in = 1'b0;
         end else if (phase_ff == sha1md_pkg::PH_LEN_LO) begin
            phase_in = sha1md_pkg::PH_DONE;
         end else if (status.wpos_14) begin
            phase_in = sha1md_pkg::PH_LEN_LO;
         end else begin
            phase_in = phase_ff;
         end
      end
      if (out_take) begin
         if (out_idx_ff == sha1md_pkg::LAST_INDEX) begin
            out_idx_in = 3'd0;
            phase_in   = sha1md_pkg::PH_NONE;
         end else begin
            out_idx_in = out_idx_ff + 3'd1;
         end
      end
   end

   // Outputs and datapath commands
   always_comb begin
      req_stall          = (state_ff != sha1md_pkg::ST_IDLE);
      rsp_valid          = (state_ff == sha1md_pkg::ST_OUT);
      rsp_word_index     = out_idx_ff;
      rsp_last_of_digest = (out_idx_ff == sha1md_pkg::LAST_INDEX);
      cmd.push    = in_take || (state_ff == sha1md_pkg::ST_PAD);
      cmd.src     = sha1md_pkg::SRC_INPUT;
      cmd.round   = (state_ff == sha1md_pkg::ST_ROUNDS);
      cmd.fold    = (state_ff == sha1md_pkg::ST_FOLD);
      cmd.clear   = out_take && (out_idx_ff == sha1md_pkg::LAST_INDEX);
      cmd.out_idx = out_idx_ff;
      if (state_ff == sha1md_pkg::ST_PAD) begin
         priority if (pad_word_ff) begin
            cmd.src = sha1md_pkg::SRC_PAD;
         end else if (phase_ff == sha1md_pkg::PH_LEN_LO) begin
            cmd.src = sha1md_pkg::SRC_LEN_LO;
         end else if (status.wpos_14) begin
            cmd.src = sha1md_pkg::SRC_LEN_HI;
         end else begin
            cmd.src = sha1md_pkg::SRC_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1md_pkg::ST_IDLE;
         phase_ff    <= sha1md_pkg::PH_NONE;
         pad_word_ff <= 1'b0;
         out_idx_ff  <= 3'd0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         pad_word_ff <= pad_word_in;
         out_idx_ff  <= out_idx_in;
      end
   end

endmodule
`default_nettype wire

### design/sha1md_datapath.sv
`default_nettype none
module sha1md_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [31:0]                req_data_word,
   input  wire logic [2:0]                 req_bytes_valid,
   input  wire logic                       req_last_word,
   input  wire sha1md_pkg::sha1md_cmd_type cmd,
   output sha1md_pkg::sha1md_status_type   status,
   output logic [31:0]                     rsp_digest_word
);

   // Schedule shift line: entry 0 holds the word of the current round
   logic [31:0] sched_ff [16];
   logic [31:0] sched_new;
   logic [31:0] wv_ff [5], wv_in [5];
   logic [31:0] chain_ff [5], chain_in [5];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [3:0]  wpos_ff, wpos_in;
   logic [6:0]  round_ff, round_in;

   logic [2:0]  nbytes;
   logic [31:0] push_word;
   logic [31:0] expand_x;
   logic [31:0] round_tmp;
   logic [31:0] a_rot5;

   assign nbytes = sha1md_pkg::clamp_bytes(req_bytes_valid, req_last_word);

   // Word source for a push
   always_comb begin
      unique case (cmd.src)
         sha1md_pkg::SRC_INPUT:  push_word = sha1md_pkg::pack_word(req_data_word, nbytes);
         sha1md_pkg::SRC_PAD:    push_word = {sha1md_pkg::PAD_BYTE, 24'h000000};
         sha1md_pkg::SRC_LEN_HI: push_word = bitlen_ff[63:32];
         sha1md_pkg::SRC_LEN_LO: push_word = bitlen_ff[31:0];
         default:                push_word = 32'h0;
      endcase
   end

   // Message expansion and round function
   assign expand_x  = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign a_rot5    = {wv_ff[0][26:0], wv_ff[0][31:27]};
   assign round_tmp = a_rot5 + sha1md_pkg::round_f(round_ff, wv_ff[1], wv_ff[2], wv_ff[3])
                      + wv_ff[4] + sched_ff[0] + sha1md_pkg::round_k(round_ff);

   // Each round appends the word needed sixteen rounds later
   always_comb begin
      sched_new = push_word;
      if (cmd.round) begin
         sched_new = {expand_x[30:0], expand_x[31]};
      end
   end

   // Working variables, chaining value, counters
   always_comb begin
      wv_in     = wv_ff;
      chain_in  = chain_ff;
      bitlen_in = bitlen_ff;
      wpos_in   = wpos_ff;
      round_in  = round_ff;
      if (cmd.push) begin
         wpos_in = wpos_ff + 4'd1;
         if (wpos_ff == 4'd15) begin
            wv_in = chain_ff;
         end
         if (cmd.src == sha1md_pkg::SRC_INPUT) begin
            bitlen_in = bitlen_ff + {58'd0, nbytes, 3'd0};
         end
      end
      if (cmd.round) begin
         wv_in[0] = round_tmp;
         wv_in[1] = wv_ff[0];
         wv_in[2] = {wv_ff[1][1:0], wv_ff[1][31:2]};
         wv_in[3] = wv_ff[2];
         wv_in[4] = wv_ff[3];
         round_in = (round_ff == sha1md_pkg::LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + wv_ff[i];
         end
      end
      if (cmd.clear) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = sha1md_pkg::INIT_CHAIN[i];
         end
         bitlen_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= sched_new;
      end
      wv_ff <= wv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= sha1md_pkg::INIT_CHAIN[i];
         end
         bitlen_ff <= 64'd0;
         wpos_ff   <= 4'd0;
         round_ff  <= 7'd0;
      end else begin
         chain_ff  <= chain_in;
         bitlen_ff <= bitlen_in;
         wpos_ff   <= wpos_in;
         round_ff  <= round_in;
      end
   end

   assign status.wpos_last  = (wpos_ff == 4'd15);
   assign status.wpos_14    = (wpos_ff == 4'd14);
   assign status.round_last = (round_ff == sha1md_pkg::LAST_ROUND);
   assign rsp_digest_word   = chain_ff[cmd.out_idx];

endmodule
`default_nettype wire

### design/sha1_message_digest_top.sv
// SHA-1 digest engine.
// Input channel (req_*): one big-endian message word per accepted word, first
// byte in bits 31..24. req_last_word marks the final word; on it
// req_bytes_valid (0..4) gives its valid leading bytes, 0 meaning none.
// Output channel (rsp_*): five digest words H0..H4 per message, with
// rsp_word_index giving each word's index and rsp_last_of_digest set on H4.
// Operation: words are taken while idle; the sixteenth word of a block starts
// the compression, 80 rounds at one round per cycle in the round unit,
// followed by the chaining add. req_stall is high during compression, padding
// and digest output.
// After the last word the pad words go in one per cycle up to the end of the
// block (one or two blocks, each then compressed), then H0 is valid.
// rsp_stall holds the current digest word until taken; the next message is
// accepted in the cycle after H4 is taken.
// Reset (synchronous) restores the initial chaining value, clears the length
// and drops any message in progress.
`default_nettype none
module sha1_message_digest_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_bytes_valid,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_of_digest
);

   sha1md_pkg::sha1md_cmd_type    cmd;
   sha1md_pkg::sha1md_status_type status;

   sha1md_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bytes_valid    (req_bytes_valid),
      .req_last_word      (req_last_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_of_digest (rsp_last_of_digest),
      .cmd                (cmd),
      .status             (status)
   );

   sha1md_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_word   (req_data_word),
      .req_bytes_valid (req_bytes_valid),
      .req_last_word   (req_last_word),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

`ifndef SYNTHESIS
   // No word is taken while a digest is being delivered
   a_no_input_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while digest pending");

   // Last flag sits on H4 only
   a_last_on_h4: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_digest == (rsp_word_index == 3'd4)))
      else $error("last_of_digest on wrong word");

   // Digest output ends after H4 is taken
   a_output_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_digest) |=> !rsp_valid)
      else $error("extra digest word after H4");

   // Index advances by one on each taken digest word below H4
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_digest)
      |=> (rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1)))
      else $error("digest index skipped");
`endif

endmodule
`default_nettype wire
